// File: src/assert_macros.svh
// Assertion macros shared by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, off while rst_ni is low.
`define IFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define IFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/ifm_pkg.sv
// Package: widths, reset values, codes and shared types of the fault monitor.
package ifm_pkg;

  localparam int unsigned TIME_WIDTH = 32;

  localparam int unsigned VOLT_W     = 13;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_GATES  = 4;
  localparam int unsigned NUM_STAMPS = 2 * NUM_GATES;
  localparam int unsigned NUM_FAULTS = 5;
  localparam int unsigned NUM_CODES  = 7;
  localparam int unsigned LED_W      = 6;

  localparam logic [VOLT_W-1:0]  VOLT_LOW_RST        = 13'd2470;
  localparam logic [VOLT_W-1:0]  VOLT_HIGH_RST       = 13'd3828;
  localparam logic [LIMIT_W-1:0] TOGGLE_LIMIT_RST    = 16'd40;
  localparam logic [LIMIT_W-1:0] STARTUP_TIMEOUT_RST = 16'd5000;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_FAULT  = 2'd2
  } mode_e;

  // Report code equals its bit position in the pending-code mask.
  typedef enum logic [2:0] {
    REP_NORMAL    = 3'd0,
    REP_REGULATOR = 3'd1,
    REP_FUSE      = 3'd2,
    REP_CHIP      = 3'd3,
    REP_PRIMARY   = 3'd4,
    REP_SECONDARY = 3'd5,
    REP_NONE      = 3'd6
  } report_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VOLT_LOW        = 2'd0,
    CFG_VOLT_HIGH       = 2'd1,
    CFG_TOGGLE_LIMIT    = 2'd2,
    CFG_STARTUP_TIMEOUT = 2'd3
  } cfg_addr_e;

  // Sticky fault bits
  localparam int unsigned F_REG  = 0;
  localparam int unsigned F_FUSE = 1;
  localparam int unsigned F_CHIP = 2;
  localparam int unsigned F_PRIM = 3;
  localparam int unsigned F_SECU = 4;

  // LED bits
  localparam int unsigned LED_START   = 0;
  localparam int unsigned LED_NORMAL  = 1;
  localparam int unsigned LED_GENERAL = 2;
  localparam int unsigned LED_ZENER   = 3;
  localparam int unsigned LED_CHIP    = 4;
  localparam int unsigned LED_TRAFO   = 5;

  // Diagnosis outcome: faults found and which level stamps take the current tick.
  typedef struct packed {
    logic [NUM_FAULTS-1:0] found;
    logic [NUM_STAMPS-1:0] stamp_we;
  } diag_t;

  // One processed item, waiting to be sent out as one or more words.
  typedef struct packed {
    logic [NUM_CODES-1:0] codes;
    mode_e                mode;
    logic [LED_W-1:0]     led;
    logic                 buzzer;
  } result_t;

endpackage

// File: src/ifm_diag.sv
// Diagnosis logic: voltage window, pin checks and the four gate toggle watchdogs.
module ifm_diag #(
  parameter int unsigned TimeWidth = ifm_pkg::TIME_WIDTH
) (
  input  logic [TimeWidth-1:0]        now_i,
  input  logic [TimeWidth-1:0]        stamp_i [ifm_pkg::NUM_STAMPS],
  input  logic [ifm_pkg::VOLT_W-1:0]  volt_low_i,
  input  logic [ifm_pkg::VOLT_W-1:0]  volt_high_i,
  input  logic [ifm_pkg::LIMIT_W-1:0] toggle_limit_i,
  input  logic [ifm_pkg::VOLT_W-1:0]  voltage_mv_i,
  input  logic                        opto_idle_i,
  input  logic                        fuse_blown_i,
  input  logic [ifm_pkg::NUM_GATES-1:0] gate_i,
  output ifm_pkg::diag_t              diag_o
);
  import ifm_pkg::*;

  logic [NUM_GATES-1:0] wd_fault;

  // Per pin: stamp 2p is the "high" stamp, 2p+1 the "low" stamp.
  for (genvar p = 0; p < NUM_GATES; p++) begin : g_pin
    logic [TimeWidth-1:0] dt;
    logic                 keep;

    assign dt = now_i - (gate_i[p] ? stamp_i[2*p] : stamp_i[2*p+1]);
    assign wd_fault[p] = (dt > TimeWidth'(toggle_limit_i)) || (gate_i[p] == gate_i[p^1]);
    // healthy and strictly inside the limit: restart the opposite level's clock
    assign keep = !wd_fault[p] && (dt < TimeWidth'(toggle_limit_i));
    assign diag_o.stamp_we[2*p]   = gate_i[p] ? wd_fault[p] : keep;
    assign diag_o.stamp_we[2*p+1] = gate_i[p] ? keep : wd_fault[p];
  end

  assign diag_o.found[F_REG]  = (voltage_mv_i < volt_low_i) || (voltage_mv_i > volt_high_i);
  assign diag_o.found[F_FUSE] = fuse_blown_i;
  assign diag_o.found[F_CHIP] = wd_fault[0] | wd_fault[1];
  assign diag_o.found[F_PRIM] = wd_fault[2] | wd_fault[3];
  assign diag_o.found[F_SECU] = opto_idle_i;

endmodule

// File: src/ifm_emit.sv
// Result register: holds one processed item and sends its report words in code order.
`include "assert_macros.svh"
module ifm_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ifm_pkg::result_t  res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ifm_pkg::report_e  report_o,
  output ifm_pkg::mode_e    mode_o,
  output logic [ifm_pkg::LED_W-1:0] led_vector_o,
  output logic              buzzer_o,
  output logic              last_o
);
  import ifm_pkg::*;

  logic                 valid_q, valid_d;
  logic [NUM_CODES-1:0] pend_q, pend_d;
  logic [NUM_CODES-1:0] pend_rest;
  mode_e                mode_q;
  logic [LED_W-1:0]     led_q;
  logic                 buzzer_q;
  logic                 word_done;

  // lowest pending code goes first
  always_comb begin
    report_o = REP_NONE;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        report_o = report_e'(3'(i));
      end
    end
  end

  assign pend_rest  = pend_q & (pend_q - 1'b1);
  assign last_o     = (pend_rest == '0);
  assign word_done  = valid_q && out_ready_i;
  assign can_load_o = !valid_q || (word_done && last_o);

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    if (word_done) begin
      pend_d = pend_rest;
      if (last_o) begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      pend_d  = res_i.codes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= '0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mode_q   <= res_i.mode;
      led_q    <= res_i.led;
      buzzer_q <= res_i.buzzer;
    end
  end

  assign out_valid_o  = valid_q;
  assign mode_o       = mode_q;
  assign led_vector_o = led_q;
  assign buzzer_o     = buzzer_q;

  `IFM_ASSERT(a_pend_nonzero, out_valid_o |-> (pend_q != '0), "valid word with no pending code")
  `IFM_ASSERT(a_load_allowed, load_i |-> can_load_o, "item loaded over undelivered words")
  `IFM_ASSERT(a_last_drops, (word_done && last_o && !load_i) |=> !out_valid_o, "valid held after last word")

endmodule

// File: src/inverter_fault_monitor_core.sv
// Top level of the inverter fault monitor: config registers, mode control, state and pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i (ready always high)
//  in      | in        | in_valid_i/in_ready_o   | voltage_mv_i, opto_idle_i, fuse_blown_i,
//          |           |                       | ic_gate_*_i, power_gate_*_i, silence_n_i
//  out     | out       | out_valid_o/out_ready_i | report_o, mode_o, led_vector_o, buzzer_o, last_o
//
// An accepted sample waits in the input register, is diagnosed and moved into the result
// register, and from there leaves as 1 to 5 report words, one per cycle while out_ready_i is high.
// The result register takes the next sample as its last word is taken, so the input register
// can accept a new sample meanwhile; input and result registers work concurrently.
// Reset clears mode, tick, stamps, sticky faults, LEDs, buzzer; config returns to reset values.
// A stalled output holds the result register; the input register fills, then in_ready_o drops.
`include "assert_macros.svh"
module inverter_fault_monitor_core #(
  parameter int unsigned TimeWidth = ifm_pkg::TIME_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ifm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ifm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ifm_pkg::VOLT_W-1:0]     voltage_mv_i,
  input  logic                           opto_idle_i,
  input  logic                           fuse_blown_i,
  input  logic                           ic_gate_a_i,
  input  logic                           ic_gate_b_i,
  input  logic                           power_gate_a_i,
  input  logic                           power_gate_b_i,
  input  logic                           silence_n_i,
  // report words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ifm_pkg::report_e               report_o,
  output ifm_pkg::mode_e                 mode_o,
  output logic [ifm_pkg::LED_W-1:0]      led_vector_o,
  output logic                           buzzer_o,
  output logic                           last_o
);
  import ifm_pkg::*;

  // config registers
  logic [VOLT_W-1:0]  volt_low_q, volt_high_q;
  logic [LIMIT_W-1:0] toggle_limit_q, startup_timeout_q;

  // input register
  logic                 s1_valid_q;
  logic [VOLT_W-1:0]    s1_volt_q;
  logic                 s1_opto_q, s1_fuse_q, s1_silence_n_q;
  logic [NUM_GATES-1:0] s1_gate_q;
  logic                 s1_adv;

  // monitor state
  mode_e                mode_q, mode_d;
  logic [TimeWidth-1:0] tick_q;
  logic [TimeWidth-1:0] start_stamp_q;
  logic [TimeWidth-1:0] stamp_q [NUM_STAMPS];
  logic [NUM_FAULTS-1:0] sticky_q;
  logic                 buzzer_q, buzzer_d;
  logic [LED_W-1:0]     led_q, led_d;

  logic                 diag_en;
  logic                 found_any;
  logic                 start_timeout;
  logic                 can_load;
  logic [NUM_CODES-1:0] codes;
  diag_t                diag;
  result_t              res;

  // ---------------------------------------------------------------- config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_low_q        <= VOLT_LOW_RST;
      volt_high_q       <= VOLT_HIGH_RST;
      toggle_limit_q    <= TOGGLE_LIMIT_RST;
      startup_timeout_q <= STARTUP_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_VOLT_LOW:        volt_low_q        <= cfg_data_i[VOLT_W-1:0];
        CFG_VOLT_HIGH:       volt_high_q       <= cfg_data_i[VOLT_W-1:0];
        CFG_TOGGLE_LIMIT:    toggle_limit_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_STARTUP_TIMEOUT: startup_timeout_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  // The sample moves on when the result register is free or frees up this cycle.
  assign s1_adv     = s1_valid_q && can_load;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_volt_q      <= voltage_mv_i;
      s1_opto_q      <= opto_idle_i;
      s1_fuse_q      <= fuse_blown_i;
      s1_gate_q      <= {power_gate_b_i, power_gate_a_i, ic_gate_b_i, ic_gate_a_i};
      s1_silence_n_q <= silence_n_i;
    end
  end

  // ---------------------------------------------------------------- diagnosis
  ifm_diag #(
    .TimeWidth(TimeWidth)
  ) u_diag (
    .now_i         (tick_q),
    .stamp_i       (stamp_q),
    .volt_low_i    (volt_low_q),
    .volt_high_i   (volt_high_q),
    .toggle_limit_i(toggle_limit_q),
    .voltage_mv_i  (s1_volt_q),
    .opto_idle_i   (s1_opto_q),
    .fuse_blown_i  (s1_fuse_q),
    .gate_i        (s1_gate_q),
    .diag_o        (diag)
  );

  assign found_any     = |diag.found;
  assign start_timeout = (tick_q - start_stamp_q) > TimeWidth'(startup_timeout_q);
  // only normal and fault modes run the diagnosis
  assign diag_en       = s1_adv && ((mode_q == MODE_NORMAL) || (mode_q == MODE_FAULT));

  // ---------------------------------------------------------------- mode: next state
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_START: begin
        if (!s1_opto_q) begin
          mode_d = MODE_NORMAL;
        end else if (start_timeout) begin
          mode_d = MODE_FAULT;
        end
      end
      MODE_NORMAL: begin
        if (found_any) begin
          mode_d = MODE_FAULT;
        end
      end
      MODE_FAULT: begin
        if (!found_any) begin
          mode_d = MODE_NORMAL;
        end
      end
      default: mode_d = mode_q;
    endcase
  end

  // ---------------------------------------------------------------- mode: outputs
  // Fault mode reports the causes that were sticky before this sample's diagnosis.
  always_comb begin
    led_d    = led_q;
    buzzer_d = buzzer_q;
    codes    = '0;
    case (mode_q)
      MODE_START: begin
        led_d[LED_START] = (!s1_opto_q || start_timeout) ? 1'b0 : 1'b1;
        codes[REP_NONE]  = 1'b1;
      end
      MODE_NORMAL: begin
        led_d             = '0;
        led_d[LED_NORMAL] = 1'b1;
        codes[REP_NORMAL] = 1'b1;
        // button clears first, a new fault then sounds the buzzer anyway
        if (!s1_silence_n_q) begin
          buzzer_d = 1'b0;
        end
        if (found_any) begin
          buzzer_d = 1'b1;
        end
      end
      MODE_FAULT: begin
        led_d[LED_NORMAL]  = 1'b0;
        led_d[LED_GENERAL] = 1'b1;
        if (sticky_q[F_REG]) begin
          led_d[LED_ZENER] = 1'b1;
        end
        if (sticky_q[F_CHIP]) begin
          led_d[LED_CHIP] = 1'b1;
        end
        if (sticky_q[F_PRIM] || sticky_q[F_SECU]) begin
          led_d[LED_TRAFO] = 1'b1;
        end
        codes[REP_REGULATOR] = sticky_q[F_REG];
        codes[REP_FUSE]      = sticky_q[F_FUSE];
        codes[REP_CHIP]      = sticky_q[F_CHIP];
        codes[REP_PRIMARY]   = sticky_q[F_PRIM];
        codes[REP_SECONDARY] = sticky_q[F_SECU];
        codes[REP_NONE]      = (sticky_q == '0);
        if (!s1_silence_n_q || !found_any) begin
          buzzer_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_START;
      tick_q        <= '0;
      start_stamp_q <= '0;
      sticky_q      <= '0;
      buzzer_q      <= 1'b0;
      led_q         <= '0;
    end else if (s1_adv) begin
      mode_q   <= mode_d;
      tick_q   <= tick_q + 1'b1;
      buzzer_q <= buzzer_d;
      led_q    <= led_d;
      if ((mode_q == MODE_START) && !s1_opto_q) begin
        start_stamp_q <= tick_q;
      end
      if (diag_en) begin
        sticky_q <= sticky_q | diag.found;
      end
    end
  end

  // level stamps take the current tick where the watchdog says so
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAMPS; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (diag_en) begin
      for (int i = 0; i < NUM_STAMPS; i++) begin
        if (diag.stamp_we[i]) begin
          stamp_q[i] <= tick_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result register
  assign res.codes  = codes;
  assign res.mode   = mode_d;
  assign res.led    = led_d;
  assign res.buzzer = buzzer_d;

  ifm_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .report_o    (report_o),
    .mode_o      (mode_o),
    .led_vector_o(led_vector_o),
    .buzzer_o    (buzzer_o),
    .last_o      (last_o)
  );

  `IFM_ASSERT(a_start_clean, (mode_q == MODE_START) |-> ((sticky_q == '0) && !buzzer_q), "faults or buzzer set in start-up")
  `IFM_ASSERT(a_buzzer_fault, buzzer_q |-> (mode_q == MODE_FAULT), "buzzer on outside fault mode")
  `IFM_ASSERT(a_tick_step, s1_adv |=> (tick_q == $past(tick_q) + 1'b1), "tick did not advance with a sample")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for inverter_fault_monitor_core: random samples, predicted reports.
`timescale 1ns / 100ps

module testbench;
  import ifm_pkg::*;

  // Reset length, settle time after the last report word, and run limit in cycles.
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  // Gate watchdog slots; each gate owns a high stamp (2g) and a low stamp (2g+1).
  localparam int unsigned GATE_IC_A = 0;
  localparam int unsigned GATE_IC_B = 1;
  localparam int unsigned GATE_PW_A = 2;
  localparam int unsigned GATE_PW_B = 3;

  // Kinds of damage applied to an otherwise healthy sample.
  typedef enum int unsigned {
    BREAK_UNDERVOLT,
    BREAK_OVERVOLT,
    BREAK_FUSE,
    BREAK_OPTO,
    BREAK_IC_PAIR,
    BREAK_PW_PAIR
  } break_e;

  // One millisecond sample, as driven on the input channel.
  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic              opto_idle;
    logic              fuse_blown;
    logic              ic_a;
    logic              ic_b;
    logic              pw_a;
    logic              pw_b;
    logic              silence_n;
  } sample_t;

  // One report word as it should leave the block.
  typedef struct packed {
    report_e          report;
    mode_e            mode;
    logic [LED_W-1:0] led;
    logic             buzzer;
    logic             last;
  } report_word_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Configuration channel.
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_addr_e             cfg_addr  = CFG_VOLT_LOW;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Sample channel.
  logic    in_valid   = 1'b0;
  logic    in_ready;
  sample_t cur_sample = '0;

  // Report channel.
  logic             out_valid;
  logic             out_ready = 1'b0;
  report_e          report;
  mode_e            mode;
  logic [LED_W-1:0] led_vector;
  logic             buzzer;
  logic             last;

  inverter_fault_monitor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .voltage_mv_i   (cur_sample.volt),
    .opto_idle_i    (cur_sample.opto_idle),
    .fuse_blown_i   (cur_sample.fuse_blown),
    .ic_gate_a_i    (cur_sample.ic_a),
    .ic_gate_b_i    (cur_sample.ic_b),
    .power_gate_a_i (cur_sample.pw_a),
    .power_gate_b_i (cur_sample.pw_b),
    .silence_n_i    (cur_sample.silence_n),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .report_o       (report),
    .mode_o         (mode),
    .led_vector_o   (led_vector),
    .buzzer_o       (buzzer),
    .last_o         (last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor state mirror: config copy plus everything the block keeps.
  // --------------------------------------------------------------------------
  logic [VOLT_W-1:0]     volt_low;
  logic [VOLT_W-1:0]     volt_high;
  logic [LIMIT_W-1:0]    toggle_limit;
  logic [LIMIT_W-1:0]    startup_timeout;

  mode_e                 mode_st;
  logic [TIME_WIDTH-1:0] tick;
  logic [TIME_WIDTH-1:0] startup_stamp;
  logic [TIME_WIDTH-1:0] level_stamp [NUM_STAMPS];
  logic [NUM_FAULTS-1:0] sticky;
  logic                  buzzer_st;
  logic [LED_W-1:0]      led_st;

  report_word_t   expected_words [$];
  sample_t        pending_samples [$];

  // Run statistics.
  int unsigned samples_accepted = 0;
  int unsigned words_checked    = 0;
  int unsigned mismatches       = 0;
  int unsigned fault_entries    = 0;
  int unsigned fault_exits      = 0;
  int unsigned settings_used    = 0;
  int unsigned code_seen [NUM_CODES];
  int unsigned cycle_count      = 0;

  // Both sides stop idling while calm is set.
  logic calm = 1'b0;

  function automatic void reset_mirror();
    volt_low        = VOLT_LOW_RST;
    volt_high       = VOLT_HIGH_RST;
    toggle_limit    = TOGGLE_LIMIT_RST;
    startup_timeout = STARTUP_TIMEOUT_RST;
    mode_st         = MODE_START;
    tick            = '0;
    startup_stamp   = '0;
    for (int i = 0; i < NUM_STAMPS; i++) level_stamp[i] = '0;
    sticky    = '0;
    buzzer_st = 1'b0;
    led_st    = '0;
  endfunction

  // Toggle watchdog for one gate; returns 1 on a stuck level or an equal pair.
  // The stamp of the current level holds the last time the gate sat at the other level.
  function automatic logic watch_gate(input logic [TIME_WIDTH-1:0] now, input logic lvl,
                                      input logic other, input int unsigned g);
    int unsigned           own;
    int unsigned           opp;
    logic [TIME_WIDTH-1:0] held;
    own  = lvl ? 2 * g : 2 * g + 1;
    opp  = lvl ? 2 * g + 1 : 2 * g;
    held = now - level_stamp[own];
    if (held > TIME_WIDTH'(toggle_limit) || lvl == other) begin
      level_stamp[own] = now;
      return 1'b1;
    end
    // exactly at the limit: tolerated, but no refresh
    if (held < TIME_WIDTH'(toggle_limit)) level_stamp[opp] = now;
    return 1'b0;
  endfunction

  function automatic logic diagnose_sample(input sample_t s, input logic [TIME_WIDTH-1:0] now);
    logic [NUM_FAULTS-1:0] found;
    logic                  chip;
    logic                  prim;
    found = '0;
    if (s.volt < volt_low || s.volt > volt_high) found[F_REG] = 1'b1;
    if (s.fuse_blown) found[F_FUSE] = 1'b1;
    // all four watchdogs run every time; keep the call order
    chip = watch_gate(now, s.ic_a, s.ic_b, GATE_IC_A);
    if (watch_gate(now, s.ic_b, s.ic_a, GATE_IC_B)) chip = 1'b1;
    prim = watch_gate(now, s.pw_a, s.pw_b, GATE_PW_A);
    if (watch_gate(now, s.pw_b, s.pw_a, GATE_PW_B)) prim = 1'b1;
    if (chip) found[F_CHIP] = 1'b1;
    if (prim) found[F_PRIM] = 1'b1;
    if (s.opto_idle) found[F_SECU] = 1'b1;
    if (!s.silence_n) buzzer_st = 1'b0;
    sticky |= found;
    return |found;
  endfunction

  // Advance the mirror by one accepted sample and queue the report words it causes.
  function automatic void predict_reports(input sample_t s);
    logic [TIME_WIDTH-1:0] now;
    report_e               codes [5];
    int unsigned           n;
    report_word_t          w;
    now = tick;
    n   = 0;
    case (mode_st)
      MODE_START: begin
        led_st[LED_START] = 1'b1;
        if (!s.opto_idle) begin
          mode_st           = MODE_NORMAL;
          led_st[LED_START] = 1'b0;
          startup_stamp     = now;
        end else if (now - startup_stamp > TIME_WIDTH'(startup_timeout)) begin
          mode_st           = MODE_FAULT;
          led_st[LED_START] = 1'b0;
        end
        codes[n++] = REP_NONE;
      end
      MODE_NORMAL: begin
        led_st             = '0;
        led_st[LED_NORMAL] = 1'b1;
        codes[n++]         = REP_NORMAL;
        if (diagnose_sample(s, now)) begin
          mode_st   = MODE_FAULT;
          buzzer_st = 1'b1;
          fault_entries++;
        end
      end
      default: begin
        // report the causes latched before this sample's own diagnosis
        led_st[LED_NORMAL]  = 1'b0;
        led_st[LED_GENERAL] = 1'b1;
        if (sticky[F_REG]) begin
          codes[n++]        = REP_REGULATOR;
          led_st[LED_ZENER] = 1'b1;
        end
        if (sticky[F_FUSE]) codes[n++] = REP_FUSE;
        if (sticky[F_CHIP]) begin
          codes[n++]       = REP_CHIP;
          led_st[LED_CHIP] = 1'b1;
        end
        if (sticky[F_PRIM]) begin
          codes[n++]        = REP_PRIMARY;
          led_st[LED_TRAFO] = 1'b1;
        end
        if (sticky[F_SECU]) begin
          codes[n++]        = REP_SECONDARY;
          led_st[LED_TRAFO] = 1'b1;
        end
        if (n == 0) codes[n++] = REP_NONE;
        if (!diagnose_sample(s, now)) begin
          mode_st   = MODE_NORMAL;
          buzzer_st = 1'b0;
          fault_exits++;
        end
      end
    endcase
    tick = now + 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      w.report = codes[k];
      w.mode   = mode_st;
      w.led    = led_st;
      w.buzzer = buzzer_st;
      w.last   = (k == n - 1);
      expected_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  // Healthy gate pattern: complementary pairs, each level held for a random run.
  logic        gen_ic      = 1'b0;
  logic        gen_pw      = 1'b1;
  int unsigned gen_ic_left = 1;
  int unsigned gen_pw_left = 1;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Run length that keeps each level short of the watchdog limit; a limit of one still gives runs of one.
  function automatic int unsigned pick_run();
    int unsigned top;
    top = (toggle_limit > 1) ? toggle_limit - 1 : 1;
    if (top > 6) top = 6;
    return $urandom_range(1, top);
  endfunction

  function automatic sample_t next_healthy();
    sample_t     s;
    int unsigned ceil_mv;
    ceil_mv = (volt_high > 5000) ? 5000 : volt_high;
    s.volt  = (volt_low <= ceil_mv) ? $urandom_range(volt_low, ceil_mv) : $urandom_range(0, 5000);
    s.opto_idle  = 1'b0;
    s.fuse_blown = 1'b0;
    s.ic_a       = gen_ic;
    s.ic_b       = ~gen_ic;
    s.pw_a       = gen_pw;
    s.pw_b       = ~gen_pw;
    s.silence_n  = ($urandom_range(0, 4) != 0);
    if (--gen_ic_left == 0) begin
      gen_ic      = ~gen_ic;
      gen_ic_left = pick_run();
    end
    if (--gen_pw_left == 0) begin
      gen_pw      = ~gen_pw;
      gen_pw_left = pick_run();
    end
    return s;
  endfunction

  // Mostly healthy samples, some with one fault injected, the rest pure noise.
  function automatic sample_t make_random_sample();
    sample_t     s;
    int unsigned r;
    logic        lvl;
    s   = next_healthy();
    r   = $urandom_range(0, 99);
    lvl = $urandom_range(0, 1);
    if (r >= 88) begin
      s.volt       = $urandom_range(0, 5000);
      s.opto_idle  = $urandom_range(0, 1);
      s.fuse_blown = $urandom_range(0, 1);
      s.ic_a       = $urandom_range(0, 1);
      s.ic_b       = $urandom_range(0, 1);
      s.pw_a       = $urandom_range(0, 1);
      s.pw_b       = $urandom_range(0, 1);
      s.silence_n  = $urandom_range(0, 1);
    end else if (r >= 75) begin
      case (break_e'($urandom_range(0, 5)))
        BREAK_UNDERVOLT: s.volt = (volt_low > 0) ? $urandom_range(0, volt_low - 1) : 0;
        BREAK_OVERVOLT:  s.volt = (volt_high < 5000) ? $urandom_range(volt_high + 1, 5000) : 5000;
        BREAK_FUSE:      s.fuse_blown = 1'b1;
        BREAK_OPTO:      s.opto_idle = 1'b1;
        BREAK_IC_PAIR: begin
          s.ic_a = lvl;
          s.ic_b = lvl;
        end
        default: begin
          s.pw_a = lvl;
          s.pw_b = lvl;
        end
      endcase
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_reports(cur_sample);
        samples_accepted++;
      end
      // valid only drops after acceptance; a new word goes out when the gap is spent
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          cur_sample <= pending_samples.pop_front();
          in_valid   <= 1'b1;
          send_gap = calm ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Report monitor and checker
  // --------------------------------------------------------------------------
  int unsigned  out_stall = 0;
  report_word_t want;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected report word: report %0d mode %0d led %b buzzer %b last %b",
                     $realtime, report, mode, led_vector, buzzer, last);
        end else begin
          want = expected_words.pop_front();
          if (report < NUM_CODES) code_seen[report]++;
          if (report !== want.report || mode !== want.mode || led_vector !== want.led ||
              buzzer !== want.buzzer || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"[%0t] word %0d mismatch: expected report %0d mode %0d led %b ",
                        "buzzer %b last %b, got report %0d mode %0d led %b buzzer %b last %b"},
                       $realtime, words_checked, want.report, want.mode, want.led,
                       want.buzzer, want.last, report, mode, led_vector, buzzer, last);
          end
        end
      end
      // backpressure: random stalls, mostly short
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = calm ? 0 : idle_len();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d report words outstanding",
               cycle_count, expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // Block is idle once nothing is queued, nothing is offered and every report has come.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_addr_e addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (addr)
      CFG_VOLT_LOW:     volt_low        = data[VOLT_W-1:0];
      CFG_VOLT_HIGH:    volt_high       = data[VOLT_W-1:0];
      CFG_TOGGLE_LIMIT: toggle_limit    = data;
      default:          startup_timeout = data;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] lo_mv, input logic [CFG_DATA_W-1:0] hi_mv,
                           input logic [CFG_DATA_W-1:0] limit, input logic [CFG_DATA_W-1:0] tmo);
    wait_idle();
    write_reg(CFG_VOLT_LOW, lo_mv);
    write_reg(CFG_VOLT_HIGH, hi_mv);
    write_reg(CFG_TOGGLE_LIMIT, limit);
    write_reg(CFG_STARTUP_TIMEOUT, tmo);
    settings_used++;
  endtask

  // Optionally stop feeding halfway until every report has drained.
  task automatic feed_random(input int unsigned count, input bit drain_midway);
    for (int unsigned i = 0; i < count; i++) begin
      pending_samples.push_back(make_random_sample());
      if (drain_midway && i == count / 2) wait_idle();
    end
  endtask

  sample_t s;
  int      boundary_mv [6] = '{0, 5000, 2470, 2469, 3828, 3829};

  initial begin
    reset_mirror();
    for (int i = 0; i < NUM_CODES; i++) code_seen[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;

    // Short start-up timeout and a tight watchdog so the directed part reaches everything.
    configure(2470, 3828, 3, 3);

    // Opto stays idle: start-up holds for the timeout, then drops into fault mode
    // with nothing latched, so the first fault reports carry "none".
    for (int i = 0; i < 5; i++) begin
      s = next_healthy();
      s.opto_idle = 1'b1;
      pending_samples.push_back(s);
    end
    s = next_healthy();
    s.silence_n = 1'b0;
    pending_samples.push_back(s);
    repeat (2) pending_samples.push_back(next_healthy());

    // Regulator window: rails and both sides of each bound.
    foreach (boundary_mv[i]) begin
      s = next_healthy();
      s.volt = boundary_mv[i];
      pending_samples.push_back(s);
    end
    s = next_healthy();
    s.fuse_blown = 1'b1;
    pending_samples.push_back(s);
    // button pressed while the fault persists: buzzer goes quiet, mode stays fault
    s = next_healthy();
    s.fuse_blown = 1'b1;
    s.silence_n  = 1'b0;
    pending_samples.push_back(s);
    s = next_healthy();
    s.opto_idle = 1'b1;
    pending_samples.push_back(s);

    // Equal levels within each pair: both high and both low.
    for (int lvl = 0; lvl < 2; lvl++) begin
      s = next_healthy();
      s.ic_a = lvl;
      s.ic_b = lvl;
      pending_samples.push_back(s);
      s = next_healthy();
      s.pw_a = lvl;
      s.pw_b = lvl;
      pending_samples.push_back(s);
    end

    // Freeze the gates: the hold passes exactly the limit, then beyond it.
    gen_ic_left = 4;
    gen_pw_left = 4;
    repeat (4) pending_samples.push_back(next_healthy());

    feed_random(50, 1'b0);

    // Widest window (upper bound written as all ones), one-tick watchdog.
    configure(0, 16'hFFFF, 1, 1);
    feed_random(50, 1'b0);

    // Largest limits; the sender also pauses halfway until everything drains.
    configure(2470, 3828, 16'hFFFF, 16'hFFFF);
    feed_random(70, 1'b1);

    // Random window and limits, no idling on either side.
    calm = 1'b1;
    configure($urandom_range(1500, 2600), $urandom_range(3000, 4800), $urandom_range(2, 60),
              $urandom_range(1, 65535));
    feed_random(70, 1'b0);
    wait_idle();
    calm = 1'b0;

    // Inverted window: every diagnosis flags the regulator.
    configure(5000, 0, 8, 5000);
    feed_random(40, 1'b0);

    // Back to the reset values.
    configure(VOLT_LOW_RST, VOLT_HIGH_RST, TOGGLE_LIMIT_RST, STARTUP_TIMEOUT_RST);
    feed_random(60, 1'b0);

    wait_idle();
    if (expected_words.size() != 0) mismatches += expected_words.size();

    $display("Covered %0d samples under %0d register settings, %0d report words checked",
             samples_accepted, settings_used, words_checked);
    $display("Fault entries %0d, recoveries %0d; words per code normal..none: %0d %0d %0d %0d %0d %0d %0d",
             fault_entries, fault_exits, code_seen[0], code_seen[1], code_seen[2], code_seen[3],
             code_seen[4], code_seen[5], code_seen[6]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
